@@ hw/rtl/bit_strip_proportional_glyph_renderer_macros.svh @@
// assertion macros shared by the renderer modules
`ifndef BIT_STRIP_PROPORTIONAL_GLYPH_RENDERER_MACROS_SVH
`define BIT_STRIP_PROPORTIONAL_GLYPH_RENDERER_MACROS_SVH

`ifndef SYNTHESIS
`define BSPGR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSPGR_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define BSPGR_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSPGR_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

@@ hw/rtl/bspgr_pkg.sv @@
`default_nettype none
package bspgr_pkg;

    localparam int unsigned STRIP_BYTES = 4096;
    localparam int unsigned NUM_CHARS   = 256;
    localparam int unsigned STRIP_AW    = $clog2(STRIP_BYTES);
    localparam int unsigned CHAR_AW     = $clog2(NUM_CHARS);
    localparam logic [5:0]  WIDTH_LIMIT = 6'd32;
    localparam logic [6:0]  MAX_ROWS    = 7'd64;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned WIN_BYTES   = 5;
    localparam int unsigned WIN_BITS    = WIN_BYTES * 8;

    typedef enum logic [2:0] {
        FN_STRIP = 3'd0,
        FN_LOC   = 3'd1,
        FN_SPC   = 3'd2,
        FN_KERN  = 3'd3,
        FN_START = 3'd4,
        FN_DRAW  = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        CFG_HEIGHT  = 3'd0,
        CFG_FIRST   = 3'd1,
        CFG_LAST    = 3'd2,
        CFG_MODULO  = 3'd3,
        CFG_DEF_SPC = 3'd4,
        CFG_USE_SPC = 3'd5,
        CFG_USE_KRN = 3'd6,
        CFG_INK     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] index;
        logic [15:0] data;
        logic [5:0]  length;
        logic [7:0]  char_code;
    } t_item;

    typedef struct packed {
        logic [5:0]  row;
        logic [15:0] x_pos;
        logic [31:0] pixel_mask;
        logic [5:0]  pixel_count;
        logic [7:0]  ink;
        logic [15:0] pen_after;
        logic        out_of_range;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [6:0]  glyph_height;
        logic [7:0]  first_char;
        logic [7:0]  last_char;
        logic [12:0] strip_modulo;
        logic [15:0] default_spacing;
        logic        use_spacing_table;
        logic        use_kerning_table;
        logic [7:0]  ink_color;
    } t_cfg;

    typedef enum logic [1:0] {
        K_STRIP = 2'd0,
        K_DRAW  = 2'd1,
        K_OOR   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [STRIP_AW-1:0]  addr;
        logic [7:0]           byte_val;
        logic [15:0]          x_pos;
        logic [15:0]          bit_off;
        logic [5:0]           count;
        logic [15:0]          pen_after;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qctl;

    typedef enum logic {
        F_IDLE,
        F_CALC
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } t_bstate;

    function automatic logic [6:0] row_total(input logic [6:0] h);
        logic [6:0] rows;
        rows = h;
        if (h == 7'd0) rows = 7'd1;
        else if (h > MAX_ROWS) rows = MAX_ROWS;
        return rows;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bspgr_queue.sv @@
`default_nettype none
`include "bit_strip_proportional_glyph_renderer_macros.svh"
module bspgr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bspgr_pkg::t_job i_job,
    input  wire logic           i_pop,
    output bspgr_pkg::t_job     o_head,
    output bspgr_pkg::t_qctl    o_ctl
);
    import bspgr_pkg::*;

    t_job                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_ctl.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_ctl.empty = (r_count == '0);
    assign do_push     = i_push && !o_ctl.full;
    assign do_pop      = i_pop && !o_ctl.empty;
    assign o_head      = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            r_count <= r_count + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
        end
    end

    `BSPGR_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_ctl.full, "push into full queue")
    `BSPGR_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_ctl.empty, "pop from empty queue")
    `BSPGR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count overflow")

endmodule
`default_nettype wire

@@ hw/rtl/bspgr_front.sv @@
`default_nettype none
module bspgr_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bspgr_pkg::t_cfg  i_cfg,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire bspgr_pkg::t_item i_item,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output bspgr_pkg::t_job       o_q_job
);
    import bspgr_pkg::*;

    logic [21:0] loc_mem  [NUM_CHARS];
    logic [15:0] spc_mem  [NUM_CHARS];
    logic [15:0] kern_mem [NUM_CHARS];

    t_fstate            r_state, n_state;
    logic [15:0]        r_pen, n_pen;
    logic [21:0]        r_loc_rd;
    logic [15:0]        r_spc_rd, r_kern_rd;
    logic               accept, oor;
    logic [CHAR_AW-1:0] rd_addr, wr_addr;
    logic [15:0]        x_pos, adv, pen_after;
    logic [5:0]         cnt;

    assign o_full  = (r_state != F_IDLE) || i_q_full;
    assign accept  = i_push && !o_full;
    assign oor     = (i_item.char_code < i_cfg.first_char) ||
                     (i_item.char_code > i_cfg.last_char);
    assign rd_addr = CHAR_AW'(i_item.char_code - i_cfg.first_char);
    assign wr_addr = i_item.index[CHAR_AW-1:0];

    assign x_pos     = r_pen + (i_cfg.use_kerning_table ? r_kern_rd : 16'd0);
    assign adv       = i_cfg.use_spacing_table ? r_spc_rd : i_cfg.default_spacing;
    assign pen_after = x_pos + adv;
    assign cnt       = (r_loc_rd[5:0] > WIDTH_LIMIT) ? WIDTH_LIMIT : r_loc_rd[5:0];

    // table stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (accept && i_item.func == FN_LOC)  loc_mem[wr_addr]  <= {i_item.data, i_item.length};
        if (accept && i_item.func == FN_SPC)  spc_mem[wr_addr]  <= i_item.data;
        if (accept && i_item.func == FN_KERN) kern_mem[wr_addr] <= i_item.data;
        r_loc_rd  <= loc_mem[rd_addr];
        r_spc_rd  <= spc_mem[rd_addr];
        r_kern_rd <= kern_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept && i_item.func == FN_DRAW && !oor) n_state = F_CALC;
            end
            F_CALC: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        n_pen    = r_pen;
        o_q_push = 1'b0;
        o_q_job  = '0;
        o_q_job.addr     = i_item.index[STRIP_AW-1:0];
        o_q_job.byte_val = i_item.data[7:0];
        o_q_job.pen_after = r_pen;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (i_item.func == FN_STRIP) begin
                        o_q_push     = 1'b1;
                        o_q_job.kind = K_STRIP;
                    end else if (i_item.func == FN_START) begin
                        n_pen = '0;
                    end else if (i_item.func == FN_DRAW && oor) begin
                        o_q_push     = 1'b1;
                        o_q_job.kind = K_OOR;
                    end
                end
            end
            F_CALC: begin
                // queue space is held since the accept cycle: only this side pushes
                o_q_push          = 1'b1;
                o_q_job.kind      = K_DRAW;
                o_q_job.x_pos     = x_pos;
                o_q_job.bit_off   = r_loc_rd[21:6];
                o_q_job.count     = cnt;
                o_q_job.pen_after = pen_after;
                n_pen             = pen_after;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_pen   <= '0;
        end else begin
            r_state <= n_state;
            r_pen   <= n_pen;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/bspgr_back.sv @@
`default_nettype none
`include "bit_strip_proportional_glyph_renderer_macros.svh"
module bspgr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bspgr_pkg::t_cfg    i_cfg,
    input  wire bspgr_pkg::t_job    i_head,
    input  wire logic               i_q_empty,
    output logic                    o_q_pop,
    output logic                    empty,
    input  wire logic               pop,
    output bspgr_pkg::t_result      o_result
);
    import bspgr_pkg::*;

    logic [7:0] strip_mem [STRIP_BYTES];

    t_bstate             r_state, n_state;
    t_job                r_job;
    logic [5:0]          r_row;
    logic [2:0]          r_k;
    logic [STRIP_AW-1:0] r_base;
    logic [7:0]          r_rd_byte;
    logic [WIN_BITS-1:0] r_win;
    t_result             r_out;
    logic                r_out_valid;
    logic [6:0]          rows;
    logic                row_last, out_free, load_out, take;
    logic [STRIP_AW-1:0] rd_addr;
    logic [31:0]         mask;
    logic [2:0]          shift;
    t_result             res;

    assign rows     = row_total(i_cfg.glyph_height);
    assign row_last = ({1'b0, r_row} + 7'd1 == rows);
    assign out_free = !r_out_valid || pop;
    assign take     = (r_state == B_IDLE) && !i_q_empty;
    assign o_q_pop  = take;
    assign empty    = !r_out_valid;
    assign o_result = r_out;
    assign shift    = r_job.bit_off[2:0];
    assign rd_addr  = r_base + r_job.bit_off[STRIP_AW+2:3] + STRIP_AW'(r_k);

    // window bit 39 is the leftmost pixel of the first byte
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            mask[j] = (6'(j) < r_job.count) &&
                      r_win[6'(WIN_BITS - 1) - 6'(shift) - 6'(j)];
        end
    end

    always_comb begin
        res = '0;
        res.pen_after = r_job.pen_after;
        if (r_job.kind == K_OOR) begin
            res.out_of_range = 1'b1;
            res.last         = 1'b1;
        end else begin
            res.row         = r_row;
            res.x_pos       = r_job.x_pos;
            res.pixel_mask  = mask;
            res.pixel_count = r_job.count;
            res.ink         = i_cfg.ink_color;
            res.last        = row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_head.kind == K_STRIP) strip_mem[i_head.addr] <= i_head.byte_val;
        r_rd_byte <= strip_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (take && i_head.kind == K_DRAW) n_state = B_READ;
                else if (take && i_head.kind == K_OOR) n_state = B_EMIT;
            end
            B_READ: begin
                if (r_k == 3'(WIN_BYTES)) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    if (r_job.kind == K_OOR || row_last) n_state = B_IDLE;
                    else n_state = B_READ;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        load_out = (r_state == B_EMIT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job  <= i_head;
            r_row  <= '0;
            r_k    <= '0;
            r_base <= '0;
        end
        if (r_state == B_READ) begin
            r_k <= r_k + 3'd1;
            for (int b = 0; b < WIN_BYTES; b++) begin
                if (r_k == 3'(b + 1)) r_win[WIN_BITS-1-8*b -: 8] <= r_rd_byte;
            end
        end
        if (load_out) begin
            r_out  <= res;
            r_row  <= r_row + 6'd1;
            r_k    <= '0;
            r_base <= r_base + i_cfg.strip_modulo[STRIP_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
        end
    end

    `BSPGR_ASSERT(a_hold_result, i_clk, i_rst_n, r_out_valid && !pop |=> r_out_valid && $stable(r_out), "result changed while stalled")
    `BSPGR_ASSERT(a_oor_last, i_clk, i_rst_n, r_out_valid && r_out.out_of_range |-> r_out.last, "range error not flagged last")
    `BSPGR_ASSERT(a_row_bound, i_clk, i_rst_n, r_state == B_EMIT && r_job.kind == K_DRAW |-> {1'b0, r_row} < rows, "row past glyph height")

endmodule
`default_nettype wire

@@ hw/rtl/bit_strip_proportional_glyph_renderer.sv @@
// channel   | direction | transfer when       | payload
// item      | in        | push && !full       | i_item (func, index, data, length, char_code)
// result    | out       | pop && !empty       | o_result (row .. last)
// config    | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
// loads and start are taken in the front's idle state; a drawn character passes
// its idle and calc states, then each glyph row takes five strip byte reads on the
// single strip port, one step to collect, one to hand the row to the output register
// reset is synchronous and active low; the stores have no clearing pass
// a four-entry job queue lets the front keep loading while rows are drawn,
// and the output register holds a result until it is popped
`default_nettype none
module bit_strip_proportional_glyph_renderer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire bspgr_pkg::t_item     i_item,
    output logic                      empty,
    input  wire logic                 pop,
    output bspgr_pkg::t_result        o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data
);
    import bspgr_pkg::*;

    t_cfg  r_cfg;
    t_job  q_in, q_head;
    t_qctl q_ctl;
    logic  q_push, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_height      <= 7'd8;
            r_cfg.first_char        <= 8'd32;
            r_cfg.last_char         <= 8'd255;
            r_cfg.strip_modulo      <= 13'd192;
            r_cfg.default_spacing   <= 16'd8;
            r_cfg.use_spacing_table <= 1'b0;
            r_cfg.use_kerning_table <= 1'b0;
            r_cfg.ink_color         <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEIGHT:  r_cfg.glyph_height      <= i_cfg_data[6:0];
                CFG_FIRST:   r_cfg.first_char        <= i_cfg_data[7:0];
                CFG_LAST:    r_cfg.last_char         <= i_cfg_data[7:0];
                CFG_MODULO:  r_cfg.strip_modulo      <= i_cfg_data[12:0];
                CFG_DEF_SPC: r_cfg.default_spacing   <= i_cfg_data;
                CFG_USE_SPC: r_cfg.use_spacing_table <= i_cfg_data[0];
                CFG_USE_KRN: r_cfg.use_kerning_table <= i_cfg_data[0];
                CFG_INK:     r_cfg.ink_color         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bspgr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_q_full (q_ctl.full),
        .o_q_push (q_push),
        .o_q_job  (q_in)
    );

    bspgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_ctl   (q_ctl)
    );

    bspgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_head    (q_head),
        .i_q_empty (q_ctl.empty),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
module tb;
    import bspgr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE      = 40;
    localparam int unsigned FONT_ROWS   = 8;
    localparam int unsigned ROW_SPAN    = 17;
    localparam int unsigned FONT_CHARS  = 16;
    localparam int unsigned OFF_SPAN    = 96;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_item       i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_result     o_result;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    bit_strip_proportional_glyph_renderer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the font stores and pen
    logic [7:0]  strip_mem [STRIP_BYTES];
    logic [15:0] loc_off   [NUM_CHARS];
    logic [5:0]  loc_len   [NUM_CHARS];
    logic [15:0] spc_mem   [NUM_CHARS];
    logic [15:0] kern_mem  [NUM_CHARS];
    logic [15:0] pen_pos;
    t_cfg        cfg_now;

    // entries that have been loaded so far
    bit          strip_set [STRIP_BYTES];
    bit          loc_set   [NUM_CHARS];
    bit          spc_set   [NUM_CHARS];
    bit          kern_set  [NUM_CHARS];

    t_result     rows_due [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;
    int unsigned pop_hold = 0;

    function automatic t_item mk(t_func f, int unsigned idx, int unsigned dat,
                                 int unsigned len, int unsigned ch);
        t_item it;
        it.func      = f;
        it.index     = idx[11:0];
        it.data      = dat[15:0];
        it.length    = len[5:0];
        it.char_code = ch[7:0];
        return it;
    endfunction

    // strip byte n of the font region: one byte left of each row start, then 16
    function automatic int unsigned font_addr(input int unsigned n);
        int unsigned r, b;
        r = n / ROW_SPAN;
        b = n % ROW_SPAN;
        return (r * 192 + b + STRIP_BYTES - 1) % STRIP_BYTES;
    endfunction

    function automatic int unsigned tbl_index();
        return $urandom_range(0, FONT_CHARS - 1) + NUM_CHARS * $urandom_range(0, 15);
    endfunction

    // a draw may only touch loaded entries
    function automatic bit draw_safe(input logic [7:0] ch);
        logic [7:0]  ci;
        logic [5:0]  cnt;
        int unsigned rows, b, addr;
        if (ch < cfg_now.first_char || ch > cfg_now.last_char)
            return 1'b1;
        ci = ch - cfg_now.first_char;
        if (!loc_set[ci])
            return 1'b0;
        if (cfg_now.use_kerning_table && !kern_set[ci])
            return 1'b0;
        if (cfg_now.use_spacing_table && !spc_set[ci])
            return 1'b0;
        cnt = (loc_len[ci] > 6'd32) ? 6'd32 : loc_len[ci];
        rows = (cfg_now.glyph_height == 0) ? 1 :
               (cfg_now.glyph_height > 64) ? 64 : cfg_now.glyph_height;
        for (int unsigned r = 0; r < rows; r++) begin
            for (int unsigned j = 0; j < cnt; j++) begin
                b = loc_off[ci] + j;
                addr = (r * cfg_now.strip_modulo + (b >> 3)) % STRIP_BYTES;
                if (!strip_set[addr])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic render_glyph(input logic [7:0] ch);
        t_result     res;
        logic [7:0]  ci;
        logic [15:0] x;
        logic [5:0]  cnt;
        int unsigned rows, b, addr;
        res = '0;
        if (ch < cfg_now.first_char || ch > cfg_now.last_char) begin
            res.pen_after    = pen_pos;
            res.out_of_range = 1'b1;
            res.last         = 1'b1;
            rows_due.push_back(res);
        end else begin
            ci = ch - cfg_now.first_char;
            if (cfg_now.use_kerning_table)
                pen_pos = pen_pos + kern_mem[ci];
            x = pen_pos;
            cnt = (loc_len[ci] > 6'd32) ? 6'd32 : loc_len[ci];
            rows = (cfg_now.glyph_height == 0) ? 1 :
                   (cfg_now.glyph_height > 64) ? 64 : cfg_now.glyph_height;
            pen_pos = pen_pos + (cfg_now.use_spacing_table ? spc_mem[ci]
                                                           : cfg_now.default_spacing);
            for (int unsigned r = 0; r < rows; r++) begin
                res = '0;
                res.row = r[5:0];
                res.x_pos = x;
                for (int unsigned j = 0; j < cnt; j++) begin
                    b = loc_off[ci] + j;
                    addr = (r * cfg_now.strip_modulo + (b >> 3)) % STRIP_BYTES;
                    // msb of a strip byte is the leftmost pixel
                    if (strip_mem[addr][7 - (b & 7)])
                        res.pixel_mask[j] = 1'b1;
                end
                res.pixel_count = cnt;
                res.ink = cfg_now.ink_color;
                res.pen_after = pen_pos;
                res.last = (r + 1 == rows);
                rows_due.push_back(res);
            end
        end
    endtask

    task automatic absorb_item(input t_item it);
        case (it.func)
            FN_STRIP: begin
                strip_mem[it.index] = it.data[7:0];
                strip_set[it.index] = 1'b1;
            end
            FN_LOC: begin
                loc_off[it.index[7:0]] = it.data;
                loc_len[it.index[7:0]] = it.length;
                loc_set[it.index[7:0]] = 1'b1;
            end
            FN_SPC: begin
                spc_mem[it.index[7:0]] = it.data;
                spc_set[it.index[7:0]] = 1'b1;
            end
            FN_KERN: begin
                kern_mem[it.index[7:0]] = it.data;
                kern_set[it.index[7:0]] = 1'b1;
            end
            FN_START: pen_pos = '0;
            FN_DRAW:  render_glyph(it.char_code);
            default: ;
        endcase
    endtask

    // drive one item and hold it until the transfer happens
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        push = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        if (typed)
            rows_due.push_back(want);
        else
            absorb_item(it);
        @(negedge i_clk);
    endtask

    task automatic send(input t_item it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic write_cfg(input t_cfg c);
        t_cfg_idx    k;
        logic [15:0] v [8];
        v[CFG_HEIGHT]  = {9'd0, c.glyph_height};
        v[CFG_FIRST]   = {8'd0, c.first_char};
        v[CFG_LAST]    = {8'd0, c.last_char};
        v[CFG_MODULO]  = {3'd0, c.strip_modulo};
        v[CFG_DEF_SPC] = c.default_spacing;
        v[CFG_USE_SPC] = {15'd0, c.use_spacing_table};
        v[CFG_USE_KRN] = {15'd0, c.use_kerning_table};
        v[CFG_INK]     = {8'd0, c.ink_color};
        push = 1'b0;
        // let the block drain before touching its registers
        wait (rows_due.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
        k = k.first();
        for (int n = 0; n < 8; n++) begin
            i_cfg_we = 1'b1;
            i_cfg_idx = k;
            i_cfg_data = v[k];
            @(negedge i_clk);
            k = k.next();
        end
        i_cfg_we = 1'b0;
        cfg_now = c;
    endtask

    task automatic random_burst(input int unsigned n);
        int unsigned sent, pick;
        logic [7:0]  ch;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            sent++;
            if (pick < 55) begin
                if (cfg_now.first_char <= cfg_now.last_char && $urandom_range(0, 9) != 0)
                    ch = 8'(cfg_now.first_char + $urandom_range(0, FONT_CHARS - 1));
                else
                    ch = 8'($urandom);
                if (draw_safe(ch))
                    send(mk(FN_DRAW, $urandom, $urandom, $urandom, ch));
                else
                    send(mk(FN_START, $urandom, $urandom, $urandom, $urandom));
            end else if (pick < 65)
                send(mk(FN_LOC, tbl_index(),
                        ($urandom_range(0, 5) == 0) ? $urandom
                                                    : $urandom_range(0, OFF_SPAN - 1),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(33, 63)
                                                    : $urandom_range(0, 32), $urandom));
            else if (pick < 72)
                send(mk(FN_SPC, tbl_index(), $urandom, $urandom, $urandom));
            else if (pick < 79)
                send(mk(FN_KERN, tbl_index(), $urandom, $urandom, $urandom));
            else if (pick < 87)
                send(mk(FN_STRIP,
                        ($urandom_range(0, 7) == 0) ? $urandom
                            : font_addr($urandom_range(0, FONT_ROWS * ROW_SPAN - 1)),
                        $urandom, $urandom, $urandom));
            else if (pick < 94)
                send(mk(FN_START, $urandom, $urandom, $urandom, $urandom));
            else begin
                // unused function codes are dropped by the block
                send(mk(t_func'($urandom_range(6, 7)), $urandom, $urandom, $urandom,
                        $urandom));
                sent--;
            end
        end
    endtask

    function automatic t_cfg random_cfg();
        t_cfg        c;
        int unsigned m;
        c.glyph_height = ($urandom_range(0, 9) == 0) ? 7'd64
                                                     : 7'($urandom_range(1, FONT_ROWS));
        c.first_char = 8'($urandom_range(0, 80));
        c.last_char = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(150, 255));
        m = $urandom_range(0, 7);
        c.strip_modulo = (m == 0) ? 13'($urandom_range(1, 4096)) :
                         (m < 3)  ? 13'd4096 : 13'd192;
        // tall glyphs stay on the first strip row
        if (c.glyph_height > 7'(FONT_ROWS))
            c.strip_modulo = 13'd4096;
        c.default_spacing = 16'($urandom);
        c.use_spacing_table = 1'($urandom);
        c.use_kerning_table = 1'($urandom);
        c.ink_color = 8'($urandom);
        return c;
    endfunction

    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(0, 3);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (rows_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $realtime, o_result);
            end else begin
                want = rows_due.pop_front();
                if (o_result !== want) begin
                    errors++;
                    $display("%0t: result mismatch expected %p actual %p",
                             $realtime, want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_step       plan [$];
        t_result     oor0;
        t_cfg        c;
        int unsigned tc;
        oor0 = '0;
        oor0.out_of_range = 1'b1;
        oor0.last = 1'b1;
        pen_pos = '0;
        cfg_now = '{7'd8, 8'd32, 8'd255, 13'd192, 16'd8, 1'b0, 1'b0, 8'd1};

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill the part of the font that the draws read
        for (int unsigned n = 0; n < FONT_ROWS * ROW_SPAN; n++)
            send(mk(FN_STRIP, font_addr(n), $urandom, $urandom, $urandom));
        for (int unsigned t = 0; t < FONT_CHARS + 2; t++) begin
            tc = (t < FONT_CHARS) ? t : (t == FONT_CHARS) ? 223 : 255;
            send(mk(FN_LOC, tc, $urandom_range(0, OFF_SPAN - 1), $urandom_range(0, 32),
                    $urandom));
            send(mk(FN_SPC, tc, $urandom_range(0, 40), $urandom, $urandom));
            send(mk(FN_KERN, tc, $urandom, $urandom, $urandom));
        end

        // directed, reset configuration
        plan.push_back('{mk(FN_START, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(FN_DRAW, 0, 0, 0, 0), 1'b1, oor0});
        plan.push_back('{mk(FN_DRAW, 0, 0, 0, 31), 1'b1, oor0});
        plan.push_back('{mk(FN_DRAW, 0, 0, 0, 32), 1'b0, '0});
        plan.push_back('{mk(FN_DRAW, 4095, 65535, 63, 255), 1'b0, '0});
        // table index above the table size wraps, oversized width saturates
        plan.push_back('{mk(FN_LOC, 300, 65535, 63, 0), 1'b0, '0});
        plan.push_back('{mk(FN_DRAW, 0, 0, 0, 76), 1'b0, '0});
        plan.push_back('{mk(FN_KERN, 4095, 16'hFFFE, 0, 0), 1'b0, '0});
        plan.push_back('{mk(FN_SPC, 44, 65535, 0, 0), 1'b0, '0});
        plan.push_back('{mk(FN_STRIP, 4095, 16'hFFFF, 0, 0), 1'b0, '0});
        plan.push_back('{mk(FN_LOC, 44, 32760, 32, 0), 1'b0, '0});
        plan.push_back('{mk(FN_DRAW, 0, 0, 0, 76), 1'b0, '0});
        plan.push_back('{mk(t_func'(6), 4095, 65535, 63, 255), 1'b0, '0});
        plan.push_back('{mk(t_func'(7), 0, 0, 0, 40), 1'b0, '0});
        plan.push_back('{mk(FN_LOC, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(FN_DRAW, 0, 0, 0, 32), 1'b0, '0});
        plan.push_back('{mk(FN_START, 4095, 65535, 63, 255), 1'b0, '0});
        plan.push_back('{mk(FN_DRAW, 0, 0, 0, 31), 1'b1, oor0});
        foreach (plan[k])
            send_item(plan[k].it, plan[k].typed, plan[k].want);

        // extremes: height zero, every code covered, tables on, widest spacing
        write_cfg('{7'd0, 8'd0, 8'd255, 13'd1, 16'hFFFF, 1'b1, 1'b1, 8'd255});
        send(mk(FN_KERN, 0, 16'h8000, 0, 0));
        send(mk(FN_DRAW, 0, 0, 0, 0));
        send(mk(FN_DRAW, 0, 0, 0, 255));
        random_burst(20);

        // tallest glyphs and the largest strip modulo
        write_cfg('{7'd127, 8'd255, 8'd255, 13'd4096, 16'd0, 1'b0, 1'b1, 8'd0});
        send(mk(FN_DRAW, 0, 0, 0, 255));
        send(mk(FN_DRAW, 0, 0, 0, 254));
        send(mk(FN_DRAW, 0, 0, 0, 255));

        // empty font range: every draw is rejected
        write_cfg('{7'd64, 8'd200, 8'd100, 13'd4095, 16'd1, 1'b0, 1'b0, 8'd128});
        random_burst(10);

        for (int p = 0; p < 6; p++) begin
            c = random_cfg();
            write_cfg(c);
            if (p == 5)
                quiet = 1'b1;
            random_burst(28);
        end

        push = 1'b0;
        wait (rows_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
